FILE: rtl/cace_pkg.sv
package cace_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 32;

    // stream payload widths
    localparam int S_TDATA_W = 40;  // key, may_fill, entry_index, zero pad
    localparam int S_TUSER_W = 2;   // req_type
    localparam int M_TDATA_W = 8;   // slot, zero pad
    localparam int M_TUSER_W = 2;   // outcome

    // field positions in the slave tdata
    localparam int KEY_LSB  = 0;
    localparam int FILL_BIT = 32;
    localparam int IDX_LSB  = 33;

    typedef enum logic [1:0] {
        REQ_ACCESS = 2'd0,
        REQ_INVAL  = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        OUT_HIT    = 2'd0,
        OUT_FILL   = 2'd1,
        OUT_NOFILL = 2'd2,
        OUT_DONE   = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP
    } t_state;

    // key store port control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

FILE: rtl/clock_aged_entry_cache.sv
// Clock-replacement key cache, one request in flight at a time.
// Invalidate / flush / unknown: result registered on acceptance, with no lookup.
// Access: keys are read from entry 0 up; a hit ends the lookup, a miss past
// the last entry gives no-fill or a may_fill sweep (one key-store read or one
// hand step per cycle through the single compare unit). Next request is taken
// once the result transaction has completed. Reset (sync, active low) clears
// all valid marks, the hand, the sequencer state and the result valid flag.
module clock_aged_entry_cache #(
    parameter int ENTRIES  = cace_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = cace_pkg::KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: key[31:0], may_fill[32], entry_index[36:33], zero[39:37]
    input  logic [cace_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: req_type[1:0]
    input  logic [cace_pkg::S_TUSER_W-1:0] i_s_tuser,
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: slot[3:0], zero[7:4]
    output logic [cace_pkg::M_TDATA_W-1:0] o_m_tdata,
    // tuser: outcome[1:0]
    output logic [cace_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import cace_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    // sequencer state
    t_state              r_state, n_state;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [IDX_W-1:0]    r_hand, n_hand;
    logic [IDX_W-1:0]    r_idx, n_idx;        // lookup read address
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;  // entry whose key is on the read port
    logic                r_rd_vld, n_rd_vld;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_fill, n_fill;

    // result register
    logic                r_m_valid, n_m_valid;
    t_outcome            r_outcome, n_outcome;
    logic [3:0]          r_slot, n_slot;

    t_mem_ctl            mem_ctl;
    logic [KEY_BITS-1:0] rd_key;
    logic                s_acc;
    logic                hit;
    logic                idx_ok;
    logic [63:0]         key_wide;
    logic [KEY_BITS-1:0] key_in;
    logic [IDX_W+3:0]    inv_ext;
    logic [IDX_W+3:0]    hand_ext;
    logic [IDX_W+3:0]    rd_ext;
    logic [IDX_W-1:0]    hand_inc;
    logic [IDX_W-1:0]    idx_inc;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE) && !r_m_valid;

    // key compared on its low KEY_BITS bits, zero extended above 32
    assign key_wide = {32'b0, i_s_tdata[KEY_LSB +: 32]};
    assign key_in   = key_wide[KEY_BITS-1:0];

    // invalidate index, out of range requests change nothing
    assign idx_ok  = 32'(i_s_tdata[IDX_LSB +: 4]) < 32'(ENTRIES);
    assign inv_ext = {IDX_W'(0), i_s_tdata[IDX_LSB +: 4]};

    // slot reports the low four bits of an entry index
    assign hand_ext = {4'b0, r_hand};
    assign rd_ext   = {4'b0, r_rd_idx};

    assign hand_inc = (r_hand == LAST) ? '0 : r_hand + IDX_W'(1);
    assign idx_inc  = (r_idx  == LAST) ? '0 : r_idx  + IDX_W'(1);

    // the one compare unit: key on the read port against the request key
    assign hit = r_rd_vld && r_valid[r_rd_idx] && (rd_key == r_key);

    cace_key_store #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_keys (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (r_hand),
        .i_wr_data (r_key),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_hand    <= '0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_hand    <= n_hand;
            r_rd_vld  <= n_rd_vld;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_rd_idx  <= n_rd_idx;
        r_key     <= n_key;
        r_fill    <= n_fill;
        r_outcome <= n_outcome;
        r_slot    <= n_slot;
    end

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_hand    = r_hand;
        n_idx     = r_idx;
        n_rd_idx  = r_rd_idx;
        n_rd_vld  = r_rd_vld;
        n_key     = r_key;
        n_fill    = r_fill;
        n_m_valid = r_m_valid;
        n_outcome = r_outcome;
        n_slot    = r_slot;
        mem_ctl   = '0;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (t_req'(i_s_tuser))
                        REQ_ACCESS: begin
                            // age out the entry under the hand first
                            n_valid[r_hand] = 1'b0;
                            n_hand          = hand_inc;
                            n_key           = key_in;
                            n_fill          = i_s_tdata[FILL_BIT];
                            n_idx           = '0;
                            n_rd_vld        = 1'b0;
                            n_state         = S_LOOK;
                        end
                        REQ_INVAL: begin
                            if (idx_ok) begin
                                n_valid[inv_ext[IDX_W-1:0]] = 1'b0;
                            end
                            n_m_valid = 1'b1;
                            n_outcome = OUT_DONE;
                            n_slot    = 4'd0;
                        end
                        REQ_FLUSH: begin
                            n_valid   = '0;
                            n_m_valid = 1'b1;
                            n_outcome = OUT_DONE;
                            n_slot    = 4'd0;
                        end
                        default: begin
                            // unknown request: no change
                            n_m_valid = 1'b1;
                            n_outcome = OUT_DONE;
                            n_slot    = 4'd0;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                // read one key per cycle, compare it in the next cycle
                mem_ctl.rd_en = 1'b1;
                n_idx         = idx_inc;
                n_rd_idx      = r_idx;
                n_rd_vld      = 1'b1;
                if (hit) begin
                    n_m_valid = 1'b1;
                    n_outcome = OUT_HIT;
                    n_slot    = rd_ext[3:0];
                    n_rd_vld  = 1'b0;
                    n_state   = S_IDLE;
                end else if (r_rd_vld && (r_rd_idx == LAST)) begin
                    n_rd_vld = 1'b0;
                    if (r_fill) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_m_valid = 1'b1;
                        n_outcome = OUT_NOFILL;
                        n_slot    = 4'd0;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_SWEEP: begin
                // hand clears valid entries until it lands on a free one
                n_hand = hand_inc;
                if (r_valid[r_hand]) begin
                    n_valid[r_hand] = 1'b0;
                end else begin
                    mem_ctl.wr_en   = 1'b1;
                    n_valid[r_hand] = 1'b1;
                    n_m_valid       = 1'b1;
                    n_outcome       = OUT_FILL;
                    n_slot          = hand_ext[3:0];
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_outcome;
    assign o_m_tdata  = {4'b0, r_slot};

    // an accepted request is either in progress or already answered
    a_acc_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state != S_IDLE) || r_m_valid)
        else $error("accepted request neither in progress nor answered");

    // the sweep always has a free entry ahead of it
    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !(&r_valid))
        else $error("sweep started with every entry valid");

    // a fill leaves its entry valid and reports it
    a_fill_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) && !r_valid[r_hand]
        |=> r_m_valid && (r_outcome == OUT_FILL) && r_valid[$past(r_hand)])
        else $error("fill not marked valid or not reported");

    // invalidate and flush leave the hand alone
    a_hand_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (i_s_tuser != REQ_ACCESS) |=> r_hand == $past(r_hand))
        else $error("hand moved on a non-access request");

    // no result is produced while one is still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && !i_m_tready |=> r_m_valid && $stable(r_outcome) && $stable(r_slot))
        else $error("pending result overwritten");

endmodule

FILE: rtl/cace_key_store.sv
module cace_key_store #(
    parameter int ENTRIES  = cace_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = cace_pkg::KEY_BITS_DEF
) (
    input  logic                       i_clk,
    input  cace_pkg::t_mem_ctl         i_ctl,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  logic [KEY_BITS-1:0]        i_wr_data,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output logic [KEY_BITS-1:0]        o_rd_data
);
    import cace_pkg::*;

    logic [KEY_BITS-1:0] r_mem [ENTRIES];
    logic [KEY_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: test/tb_clock_aged_entry_cache.sv
`timescale 1ns / 100ps

module tb_clock_aged_entry_cache;

    import cace_pkg::*;

    localparam int ENTRIES  = ENTRIES_DEF;
    localparam int KEY_BITS = KEY_BITS_DEF;

    // tuser code the block does not define; it must act as a no-op
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam int MAX_WAIT    = 13;    // longest per-transaction gap or stall
    localparam int HOLD_CYCLES = 200;   // long receiver hold-off
    // The worst access is a full lookup followed by a sweep, with gaps and stalls
    // on each side. The hold-off is the longest quiet stretch, so the limit is
    // several times that value.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 4 * ENTRIES;

    typedef struct {
        t_outcome   outcome;
        logic [3:0] slot;
    } t_cache_result;

    // ------------------------------------------------------------------
    // DUT ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // tdata: key[31:0], may_fill[32], entry_index[36:33], zero[39:37]
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    // tuser: req_type[1:0]
    logic [S_TUSER_W-1:0] i_s_tuser  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // tdata: slot[3:0], zero[7:4]
    logic [M_TDATA_W-1:0] o_m_tdata;
    // tuser: outcome[1:0]
    logic [M_TUSER_W-1:0] o_m_tuser;

    clock_aged_entry_cache #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_cache_result  pending_results[$];   // predictions waiting for their result
    bit             entry_valid [ENTRIES];
    logic [31:0]    entry_key   [ENTRIES];
    int             hand_pos;

    bit   gap_en       = 1'b0;           // sender idles between transactions
    bit   stall_en     = 1'b0;           // receiver stalls between transactions
    logic hold_pending = 1'b0;           // request a long receiver hold-off
    int   err_cnt      = 0;
    int   sent_cnt     = 0;
    int   outcome_cnt [4];
    logic [31:0] key_pool [24];

    // ------------------------------------------------------------------
    // Predictor: advances the table copy for one accepted request
    // ------------------------------------------------------------------
    function automatic t_cache_result cache_lookup_step(input logic [1:0] req,
                                                        input logic [31:0] key,
                                                        input logic fill,
                                                        input logic [3:0] idx);
        t_cache_result res;
        int            hit_at;
        int            swept;
        res.outcome = OUT_DONE;
        res.slot    = '0;
        hit_at      = -1;
        swept       = 0;
        case (req)
            REQ_ACCESS: begin
                // age step: the entry under the hand is dropped before the lookup
                entry_valid[hand_pos] = 1'b0;
                hand_pos = (hand_pos + 1) % ENTRIES;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (hit_at < 0 && entry_valid[i] && entry_key[i] == key)
                        hit_at = i;
                end
                if (hit_at >= 0) begin
                    res.outcome = OUT_HIT;
                    res.slot    = 4'(hit_at);
                end else if (fill) begin
                    // sweep: clear valid entries until a free one turns up
                    while (entry_valid[hand_pos] && swept < ENTRIES) begin
                        entry_valid[hand_pos] = 1'b0;
                        hand_pos = (hand_pos + 1) % ENTRIES;
                        swept++;
                    end
                    res.outcome = OUT_FILL;
                    res.slot    = 4'(hand_pos);
                    entry_key[hand_pos]   = key;
                    entry_valid[hand_pos] = 1'b1;
                    hand_pos = (hand_pos + 1) % ENTRIES;
                end else begin
                    res.outcome = OUT_NOFILL;
                end
            end
            REQ_INVAL: begin
                if (idx < ENTRIES)
                    entry_valid[idx] = 1'b0;
            end
            REQ_FLUSH: begin
                foreach (entry_valid[i]) entry_valid[i] = 1'b0;
            end
            default: ;   // unknown type leaves the table alone
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one request transaction. Call and return at a rising edge.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] req, input logic [31:0] key,
                                input logic fill, input logic [3:0] idx);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        gap  = gap_en ? $urandom_range(0, MAX_WAIT) : 0;
        word = '0;
        word[KEY_LSB +: 32] = key;
        word[FILL_BIT]      = fill;
        word[IDX_LSB +: 4]  = idx;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= req;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(cache_lookup_step(req, key, fill, idx));
        sent_cnt++;
    endtask

    // Sender goes quiet until every predicted result has been seen.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random per-transaction stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    int ready_wait = 0;
    int hold_left  = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            ready_wait = stall_en ? $urandom_range(0, MAX_WAIT) : 0;
        if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (ready_wait > 0) begin
            ready_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result check: each result transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cache_result exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            outcome_cnt[o_m_tuser]++;
            if (pending_results.size() == 0) begin
                $error("result with no request pending: outcome %0d slot %0d",
                       o_m_tuser, o_m_tdata[3:0]);
                err_cnt++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_m_tuser !== exp_res.outcome) begin
                    $error("outcome mismatch: expected %0d, actual %0d",
                           exp_res.outcome, o_m_tuser);
                    err_cnt++;
                end
                if (o_m_tdata[3:0] !== exp_res.slot) begin
                    $error("slot mismatch: expected %0d, actual %0d",
                           exp_res.slot, o_m_tdata[3:0]);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles with no transaction on either side.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_clock_aged_entry_cache: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Key extremes, every request type, hit/fill/no-fill, invalidates at both
    // ends of the index range, flush, and the undefined request code.
    task automatic test_directed();
        send_request(REQ_ACCESS, 32'h0000_0000, 1'b0, 4'd0);  // empty table, no fill
        send_request(REQ_ACCESS, 32'h0000_0000, 1'b1, 4'd0);  // fill
        send_request(REQ_ACCESS, 32'h0000_0000, 1'b1, 4'd0);  // hit
        send_request(REQ_ACCESS, 32'hFFFF_FFFF, 1'b1, 4'd15);
        send_request(REQ_ACCESS, 32'hFFFF_FFFF, 1'b0, 4'd15);
        send_request(REQ_ACCESS, 32'h8000_0001, 1'b1, 4'd0);
        send_request(REQ_ACCESS, 32'h7FFF_FFFE, 1'b1, 4'd0);
        send_request(REQ_ACCESS, 32'h0000_0000, 1'b0, 4'd0);
        send_request(REQ_INVAL,  32'h0000_0000, 1'b0, 4'd0);
        send_request(REQ_INVAL,  32'hFFFF_FFFF, 1'b1, 4'd15);
        send_request(REQ_INVAL,  32'h0000_0000, 1'b0, 4'b0101);
        send_request(REQ_INVAL,  32'h0000_0000, 1'b0, 4'b1010);
        send_request(REQ_ACCESS, 32'h8000_0001, 1'b0, 4'd0);
        send_request(REQ_FLUSH,  32'h0000_0000, 1'b0, 4'd0);
        send_request(REQ_ACCESS, 32'hFFFF_FFFF, 1'b0, 4'd0);  // flushed: miss
        send_request(REQ_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 4'd15);
        send_request(REQ_UNKNOWN, 32'h0000_0000, 1'b0, 4'd0);
        // a run of fills, then hits on two of them, then a fill of a new key
        // that finds a free entry under the hand
        for (int i = 0; i < 5; i++)
            send_request(REQ_ACCESS, 32'hA5A5_0000 + i, 1'b1, 4'd0);
        send_request(REQ_ACCESS, 32'hA5A5_0003, 1'b1, 4'd0);
        send_request(REQ_ACCESS, 32'hA5A5_0004, 1'b1, 4'd0);
        send_request(REQ_ACCESS, 32'h5A5A_FFFF, 1'b1, 4'd0);
    endtask

    // Mixed traffic. Keys come mostly from the first key_span pool entries, so a
    // small span gives many hits and a large one gives eviction churn.
    task automatic test_random_traffic(input int n_items, input int key_span);
        int          pick;
        logic [31:0] key;
        logic        fill;
        logic [3:0]  idx;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            key  = key_pool[$urandom_range(0, key_span - 1)];
            fill = ($urandom_range(0, 4) != 0);
            idx  = 4'($urandom_range(0, 15));
            if (pick < 78)
                send_request(REQ_ACCESS, key, fill, idx);
            else if (pick < 86)
                send_request(REQ_ACCESS, $urandom, fill, idx);
            else if (pick < 94)
                send_request(REQ_INVAL, $urandom, fill, idx);
            else if (pick < 97)
                send_request(REQ_FLUSH, $urandom, fill, idx);
            else
                send_request(REQ_UNKNOWN, $urandom, fill, idx);
        end
    endtask

    // Both sides ready all the time: back-to-back transactions.
    task automatic test_back_to_back();
        gap_en   = 1'b0;
        stall_en = 1'b0;
        test_random_traffic(100, 12);
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    // The block fills and stalls its input. The sender then pauses until
    // every result has arrived.
    task automatic test_output_holdoff();
        gap_en   = 1'b0;
        stall_en = 1'b1;
        hold_pending <= 1'b1;
        test_random_traffic(20, 8);
        wait_idle();
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        foreach (outcome_cnt[i]) outcome_cnt[i] = 0;
        // reference copy of the reset state
        foreach (entry_valid[i]) begin
            entry_valid[i] = 1'b0;
            entry_key[i]   = '0;
        end
        hand_pos = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_en   = 1'b1;
        stall_en = 1'b1;
        test_directed();
        test_random_traffic(300, 6);    // hit-heavy
        test_random_traffic(500, 24);   // pool larger than the table
        test_back_to_back();
        test_output_holdoff();
        gap_en   = 1'b1;
        stall_en = 1'b1;
        test_random_traffic(300, 12);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests: access/invalidate/flush/undefined, idle and stalled",
                 sent_cnt);
        $display("results seen: %0d hit, %0d fill, %0d no-fill, %0d done",
                 outcome_cnt[OUT_HIT], outcome_cnt[OUT_FILL],
                 outcome_cnt[OUT_NOFILL], outcome_cnt[OUT_DONE]);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("tb_clock_aged_entry_cache: PASS");
        end else begin
            $display("tb_clock_aged_entry_cache: FAIL");
        end
        $finish;
    end

endmodule
